FILE: rtl/dte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dte_pkg: shared types and constants for digit transition effects
// Effect and phase codes, stroke and slice tables, register map.
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int DIGITS = 9;
  localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [4:0] DIGITS_V = 5'(DIGITS);

  typedef logic [15:0] seg_t;
  typedef logic [5:0]  level_t;
  typedef logic [1:0]  phase_t;
  typedef logic [2:0]  mode_t;

  localparam level_t FULL_LEVEL   = 6'd50;
  localparam seg_t   NUMERAL_MASK = 16'h007F;

  // effect modes
  localparam mode_t MODE_CUT    = 3'd0;
  localparam mode_t MODE_XFADE  = 3'd1;
  localparam mode_t MODE_FADE   = 3'd2;
  localparam mode_t MODE_STROKE = 3'd3;
  localparam mode_t MODE_ROLL   = 3'd4;
  localparam mode_t MODE_RESET  = MODE_ROLL;

  // animation phases
  localparam phase_t PH_IDLE   = 2'd0;
  localparam phase_t PH_FIRST  = 2'd1;
  localparam phase_t PH_SECOND = 2'd2;

  // register map
  localparam int         CFG_AW           = 3;
  localparam logic [2:0] ADDR_EFFECT_MODE = 3'd0;

  // floor(p / 50) for p < 512 as (p * 41) >> 11
  localparam int DIV50_MUL   = 41;
  localparam int DIV50_SHIFT = 11;

  typedef logic [6:0][6:0] stroke_row_t;

  function automatic stroke_row_t stroke_row(input logic [3:0] v);
    stroke_row_t r;
    r = '0;
    case (v)
      4'd0: r = {7'h00, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
      4'd1: r = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h04, 7'h02};
      4'd2: r = {7'h00, 7'h00, 7'h08, 7'h10, 7'h40, 7'h02, 7'h01};
      4'd3: r = {7'h00, 7'h00, 7'h08, 7'h04, 7'h40, 7'h02, 7'h01};
      4'd4: r = {7'h00, 7'h00, 7'h00, 7'h04, 7'h02, 7'h40, 7'h20};
      4'd5: r = {7'h00, 7'h00, 7'h08, 7'h04, 7'h40, 7'h20, 7'h01};
      4'd6: r = {7'h00, 7'h40, 7'h04, 7'h08, 7'h10, 7'h20, 7'h01};
      4'd7: r = {7'h00, 7'h00, 7'h00, 7'h00, 7'h04, 7'h02, 7'h01};
      4'd8: r = {7'h20, 7'h04, 7'h08, 7'h10, 7'h40, 7'h02, 7'h01};
      4'd9: r = {7'h00, 7'h08, 7'h04, 7'h40, 7'h20, 7'h01, 7'h02};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] stroke_total(input logic [3:0] v);
    logic [2:0] n;
    n = 3'd0;
    case (v)
      4'd0: n = 3'd6;
      4'd1: n = 3'd2;
      4'd2: n = 3'd5;
      4'd3: n = 3'd5;
      4'd4: n = 3'd4;
      4'd5: n = 3'd5;
      4'd6: n = 3'd6;
      4'd7: n = 3'd3;
      4'd8: n = 3'd7;
      4'd9: n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // union of the first s/10 roll slices, at most four (top, upper sides, middle, ...)
  function automatic logic [6:0] roll_mask(input logic [6:0] s);
    logic [6:0] m;
    m = 7'h00;
    if (s >= 7'd10) m = m | 7'h01;
    if (s >= 7'd20) m = m | 7'h22;
    if (s >= 7'd30) m = m | 7'h40;
    if (s >= 7'd40) m = m | 7'h14;
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dte_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dte_in_if: frame tick request channel
// Valid/ready channel carrying digit index, target word and numeral.
// ----------------------------------------------------------------------------
interface dte_in_if;
  import dte_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] digit_index;
  seg_t       target_segs;
  logic [3:0] digit_value;

  modport source (output valid, output digit_index, output target_segs,
                  output digit_value, input ready);
  modport sink   (input valid, input digit_index, input target_segs,
                  input digit_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/dte_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dte_out_if: result request channel
// Valid/ready channel carrying shown and previous words with levels.
// ----------------------------------------------------------------------------
interface dte_out_if;
  import dte_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] out_digit;
  seg_t       shown_segs;
  seg_t       prior_segs;
  level_t     new_bright;
  level_t     old_bright;

  modport source (output valid, output out_digit, output shown_segs,
                  output prior_segs, output new_bright, output old_bright,
                  input ready);
  modport sink   (input valid, input out_digit, input shown_segs,
                  input prior_segs, input new_bright, input old_bright,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/digit_transition_effects_core.sv
`default_nettype none
// Path: a request accepted into the input register moves on to the result
//   register when that is free or being emptied, else dout.ready holds it back.
// Throughput: one request per cycle while dout.ready allows, to the same digit or
//   any other; per digit state is read and written in the cycle the result is formed.
// Reset (rst, synchronous): every digit idle at full step, words cleared,
//   effect_mode set to roll; both pipeline registers empty.
// ----------------------------------------------------------------------------
// digit_transition_effects_core: per digit transition animator
// Tracks target changes per digit and steps cut, crossfade, fade, stroke or
// roll animations once per frame tick, reporting words and levels.
// ----------------------------------------------------------------------------
module digit_transition_effects_core (
  input  wire                         clk,
  input  wire                         rst,
  dte_in_if.sink                      din,
  dte_out_if.source                   dout,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [dte_pkg::CFG_AW-1:0]   paddr,
  input  wire [31:0]                  pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dte_pkg::*;

  // ---------------------------------------------------------------- config
  mode_t mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_EFFECT_MODE) begin
      mode <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_EFFECT_MODE) begin
      prdata = {29'd0, mode};
    end
  end

  // -------------------------------------------------------- pipeline control
  // adv: the result register is free (or being emptied) this cycle, so the
  // request in the input register is worked, an existing digit's state written back.
  logic       in_vld;
  logic [3:0] in_digit;
  seg_t       in_target;
  logic [3:0] in_value;
  logic       out_vld;
  logic       adv;

  assign adv       = !out_vld || dout.ready;
  assign din.ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (din.ready) begin
      in_vld <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_digit  <= din.digit_index;
      in_target <= din.target_segs;
      in_value  <= din.digit_value;
    end
  end

  // -------------------------------------------------------- per digit state
  seg_t   last_target [DIGITS];
  seg_t   cur_segs    [DIGITS];
  seg_t   prev_segs   [DIGITS];
  level_t step_count  [DIGITS];
  phase_t phase       [DIGITS];

  // ----------------------------------------------------------- frame step
  logic [DIG_W-1:0] sel;
  logic             dig_ok;
  seg_t             cur_next;
  seg_t             prev_next;
  logic [6:0]       step_next;
  phase_t           phase_next;
  level_t           nb;
  level_t           ob;

  always_comb begin
    logic [6:0]  s2;
    logic [6:0]  s3;
    logic [6:0]  s4;
    logic [8:0]  prod;
    logic [14:0] quo;
    logic [2:0]  n;
    logic [6:0]  strokes;
    logic [6:0]  slices;
    logic [5:0]  lvl;
    stroke_row_t row;
    seg_t        base;

    sel    = in_digit[DIG_W-1:0];
    dig_ok = {1'b0, in_digit} < DIGITS_V;
    base   = in_target & ~NUMERAL_MASK;

    cur_next   = cur_segs[sel];
    prev_next  = prev_segs[sel];
    step_next  = {1'b0, step_count[sel]};
    phase_next = phase[sel];

    // target change: kick off a transition in the current mode
    if (in_target != last_target[sel]) begin
      case (mode)
        MODE_CUT: begin
          prev_next = cur_segs[sel];
          cur_next  = in_target;
          step_next = {1'b0, FULL_LEVEL};
        end
        MODE_XFADE: begin
          prev_next = cur_segs[sel];
          cur_next  = in_target;
          step_next = 7'd0;
        end
        MODE_FADE, MODE_ROLL: begin
          prev_next  = cur_segs[sel];
          step_next  = 7'd0;
          phase_next = PH_FIRST;
        end
        MODE_STROKE: begin
          prev_next = cur_segs[sel];
          cur_next  = base;
          step_next = 7'd0;
        end
        default: begin
        end
      endcase
    end

    s2 = step_next + 7'd2;
    s3 = step_next + 7'd3;
    s4 = step_next + 7'd4;
    if (s3 > {1'b0, FULL_LEVEL}) s3 = {1'b0, FULL_LEVEL};

    // strokes drawn so far: floor(s * total / 50) by reciprocal multiply
    prod    = 9'(s3[5:0]) * 9'(stroke_total(in_value));
    quo     = (15'(prod) * 15'(DIV50_MUL)) >> DIV50_SHIFT;
    n       = quo[2:0];
    row     = stroke_row(in_value);
    strokes = 7'h00;
    for (int k = 0; k < 7; k++) begin
      if (3'(k) < n) strokes = strokes | row[k];
    end
    slices = roll_mask(s4);

    // one animation frame
    case (mode)
      MODE_XFADE: begin
        if (step_next < {1'b0, FULL_LEVEL}) begin
          step_next = (s2 > {1'b0, FULL_LEVEL}) ? {1'b0, FULL_LEVEL} : s2;
        end
      end
      MODE_FADE: begin
        if (phase_next == PH_FIRST) begin
          if (s4 >= {1'b0, FULL_LEVEL}) begin
            cur_next   = in_target;
            step_next  = 7'd0;
            phase_next = PH_SECOND;
          end else begin
            step_next = s4;
          end
        end else if (phase_next == PH_SECOND) begin
          if (s4 >= {1'b0, FULL_LEVEL}) begin
            step_next  = {1'b0, FULL_LEVEL};
            phase_next = PH_IDLE;
          end else begin
            step_next = s4;
          end
        end
      end
      MODE_STROKE: begin
        if (in_target == '0) begin
          cur_next  = '0;
          step_next = {1'b0, FULL_LEVEL};
        end else if (step_next < {1'b0, FULL_LEVEL}) begin
          step_next = s3;
          cur_next  = base | {9'd0, strokes};
        end
      end
      MODE_ROLL: begin
        // first half clears slices top-down, second half draws the new target's slices in
        if (phase_next == PH_FIRST) begin
          if (s4 >= {1'b0, FULL_LEVEL}) begin
            step_next  = 7'd0;
            phase_next = PH_SECOND;
          end else begin
            step_next = s4;
            cur_next  = prev_next & ~{9'd0, slices};
          end
        end else if (phase_next == PH_SECOND) begin
          if (s4 >= {1'b0, FULL_LEVEL}) begin
            step_next  = {1'b0, FULL_LEVEL};
            phase_next = PH_IDLE;
            cur_next   = in_target;
          end else begin
            step_next = s4;
            cur_next  = base | (in_target & {9'd0, slices});
          end
        end
      end
      default: begin
      end
    endcase

    // brightness levels
    lvl = (step_next > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : step_next[5:0];
    nb  = '0;
    ob  = '0;
    case (mode)
      MODE_CUT, MODE_STROKE, MODE_ROLL: begin
        nb = FULL_LEVEL;
      end
      MODE_XFADE: begin
        nb = lvl;
        ob = FULL_LEVEL - lvl;
      end
      MODE_FADE: begin
        if (phase_next == PH_FIRST) begin
          ob = FULL_LEVEL - lvl;
        end else if (phase_next == PH_SECOND) begin
          nb = lvl;
        end else begin
          nb = FULL_LEVEL;
        end
      end
      default: begin
      end
    endcase
  end

  // state write-back, only for a digit that exists
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        last_target[i] <= '0;
        cur_segs[i]    <= '0;
        prev_segs[i]   <= '0;
        step_count[i]  <= FULL_LEVEL;
        phase[i]       <= PH_IDLE;
      end
    end else if (in_vld && adv && dig_ok) begin
      last_target[sel] <= in_target;
      cur_segs[sel]    <= cur_next;
      prev_segs[sel]   <= prev_next;
      step_count[sel]  <= step_next[5:0];
      phase[sel]       <= phase_next;
    end
  end

  // -------------------------------------------------------- result register
  logic [3:0] res_digit;
  seg_t       res_shown;
  seg_t       res_prior;
  level_t     res_nb;
  level_t     res_ob;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && adv) begin
      res_digit <= in_digit;
      res_shown <= dig_ok ? cur_next  : '0;
      res_prior <= dig_ok ? prev_next : '0;
      res_nb    <= dig_ok ? nb : '0;
      res_ob    <= dig_ok ? ob : '0;
    end
  end

  assign dout.valid      = out_vld;
  assign dout.out_digit  = res_digit;
  assign dout.shown_segs = res_shown;
  assign dout.prior_segs = res_prior;
  assign dout.new_bright = res_nb;
  assign dout.old_bright = res_ob;

`ifndef SYNTHESIS
  // a digit outside the display reports zero words and levels
  a_bad_digit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && {1'b0, res_digit} >= DIGITS_V) |->
      (res_shown == '0 && res_prior == '0 && res_nb == '0 && res_ob == '0))
    else $error("out-of-range digit gave non-zero result");

  // the two levels never add up beyond full
  a_level_sum: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> ({1'b0, res_nb} + {1'b0, res_ob} <= {1'b0, FULL_LEVEL}))
    else $error("brightness levels exceed full scale");

  // a worked request always lands in the result register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_vld && adv) |=> out_vld)
    else $error("worked request lost before result register");

  // input register is not overwritten while it holds an unworked request
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !adv) |-> !din.ready)
    else $error("input register overrun");
`endif

endmodule
`default_nettype wire

FILE: test/tb_digit_transition_effects_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_digit_transition_effects_core: self-checking bench for the transition core
// Drives frame tick requests for all digits and each effect mode, including
// the undefined codes. A behavioural model of the per-digit animation
// predicts every result, and a scoreboard compares each field in order. Both
// channel sides idle at random, and the result side holds off once for a long
// stretch so that the core backs up.
// ----------------------------------------------------------------------------
module tb_digit_transition_effects_core;
  import dte_pkg::*;

  // undefined effect codes: a new target is latched, nothing animates
  localparam mode_t MODE_SPARE_LO  = 3'd5;
  localparam mode_t MODE_SPARE_MID = 3'd6;
  localparam mode_t MODE_SPARE_HI  = 3'd7;

  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 300;   // the one long result-side hold-off
  localparam int HOLD_AFTER    = 300;   // results seen before that hold-off
  localparam int PHASE_TICKS   = 85;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 4;     // wait ahead of the drain check

  // drawing order per numeral, and how many strokes each numeral has
  localparam logic [6:0] STROKE_ORDER [10][7] = '{
    '{7'h20, 7'h10, 7'h08, 7'h04, 7'h02, 7'h01, 7'h00},
    '{7'h02, 7'h04, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h02, 7'h40, 7'h10, 7'h08, 7'h00, 7'h00},
    '{7'h01, 7'h02, 7'h40, 7'h04, 7'h08, 7'h00, 7'h00},
    '{7'h20, 7'h40, 7'h02, 7'h04, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h20, 7'h40, 7'h04, 7'h08, 7'h00, 7'h00},
    '{7'h01, 7'h20, 7'h10, 7'h08, 7'h04, 7'h40, 7'h00},
    '{7'h01, 7'h02, 7'h04, 7'h00, 7'h00, 7'h00, 7'h00},
    '{7'h01, 7'h02, 7'h40, 7'h10, 7'h08, 7'h04, 7'h20},
    '{7'h02, 7'h01, 7'h20, 7'h40, 7'h04, 7'h08, 7'h00}
  };
  localparam int STROKE_COUNT [10] = '{6, 2, 5, 5, 4, 5, 6, 3, 7, 6};

  // roll slices from the top: A, then B+F, G, C+E, D
  localparam logic [6:0] ROLL_SLICE [5] = '{7'h01, 7'h22, 7'h40, 7'h14, 7'h08};

  // the modes stepped through by the random part, extremes included
  localparam mode_t RUN_MODES [12] = '{
    MODE_ROLL, MODE_FADE, MODE_STROKE, MODE_XFADE, MODE_CUT, MODE_SPARE_LO,
    MODE_FADE, MODE_ROLL, MODE_STROKE, MODE_SPARE_HI, MODE_XFADE, MODE_SPARE_MID
  };

  typedef struct packed {
    logic [3:0] digit;
    seg_t       target;
    logic [3:0] numeral;
  } tick_t;

  typedef struct packed {
    logic [3:0] digit;
    seg_t       shown;
    seg_t       prior;
    level_t     new_lvl;
    level_t     old_lvl;
  } frame_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of every digit's animation state, works
  // out the frame each accepted tick must produce and matches results in order.
  // --------------------------------------------------------------------------
  class transition_scoreboard;
    mode_t  mode;
    seg_t   last_tgt [DIGITS];
    seg_t   shown    [DIGITS];
    seg_t   prior    [DIGITS];
    int     steps    [DIGITS];
    phase_t ph       [DIGITS];
    frame_t frames_due [$];
    int     failures;
    int     results_seen;

    function new();
      mode = MODE_RESET;
      failures = 0;
      results_seen = 0;
      for (int d = 0; d < DIGITS; d++) begin
        last_tgt[d] = '0;
        shown[d]    = '0;
        prior[d]    = '0;
        steps[d]    = FULL_LEVEL;
        ph[d]       = PH_IDLE;
      end
    endfunction

    function void fault(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // one frame of animation for one digit
    function frame_t animate_tick(tick_t r);
      frame_t o;
      int     d, s, n, strokes;
      seg_t   t, acc;
      o = '0;
      o.digit = r.digit;
      d = r.digit;
      if (d >= DIGITS) return o;   // unknown digit: zero words and levels, nothing stored
      t = r.target;

      // target changed: kick off a transition
      if (t != last_tgt[d]) begin
        last_tgt[d] = t;
        case (mode)
          MODE_CUT: begin
            prior[d] = shown[d]; shown[d] = t; steps[d] = FULL_LEVEL;
          end
          MODE_XFADE: begin
            prior[d] = shown[d]; shown[d] = t; steps[d] = 0;
          end
          MODE_FADE, MODE_ROLL: begin
            prior[d] = shown[d]; steps[d] = 0; ph[d] = PH_FIRST;
          end
          MODE_STROKE: begin
            prior[d] = shown[d]; shown[d] = t & ~NUMERAL_MASK; steps[d] = 0;
          end
          default: ;
        endcase
      end

      // advance this frame
      s = steps[d];
      case (mode)
        MODE_XFADE: begin
          if (s < FULL_LEVEL) steps[d] = (s + 2 > FULL_LEVEL) ? FULL_LEVEL : s + 2;
        end
        MODE_FADE: begin
          if (ph[d] == PH_FIRST) begin
            s += 4;
            if (s >= FULL_LEVEL) begin
              shown[d] = t; s = 0; ph[d] = PH_SECOND;
            end
            steps[d] = s;
          end else if (ph[d] == PH_SECOND) begin
            s += 4;
            if (s >= FULL_LEVEL) begin
              s = FULL_LEVEL; ph[d] = PH_IDLE;
            end
            steps[d] = s;
          end
        end
        MODE_STROKE: begin
          if (t == '0) begin
            shown[d] = '0; steps[d] = FULL_LEVEL;
          end else if (s < FULL_LEVEL) begin
            s = (s + 3 > FULL_LEVEL) ? FULL_LEVEL : s + 3;
            steps[d] = s;
            strokes = (r.numeral <= 4'd9) ? STROKE_COUNT[r.numeral] : 0;
            n = (s * strokes) / FULL_LEVEL;
            acc = t & ~NUMERAL_MASK;
            for (int k = 0; k < n && k < 7; k++) acc |= STROKE_ORDER[r.numeral][k];
            shown[d] = acc;
          end
        end
        MODE_ROLL: begin
          if (ph[d] == PH_FIRST) begin
            s += 4;
            if (s >= FULL_LEVEL) begin
              s = 0; ph[d] = PH_SECOND;
            end else begin
              // wipe the old word away from the top
              n = s / 10;
              acc = prior[d];
              for (int k = 0; k < n && k < 5; k++) acc &= ~{9'b0, ROLL_SLICE[k]};
              shown[d] = acc;
            end
            steps[d] = s;
          end else if (ph[d] == PH_SECOND) begin
            s += 4;
            if (s >= FULL_LEVEL) begin
              s = FULL_LEVEL; ph[d] = PH_IDLE; shown[d] = t;
            end else begin
              // draw the new word in from the top
              n = s / 10;
              acc = t & ~NUMERAL_MASK;
              for (int k = 0; k < n && k < 5; k++) acc |= t & {9'b0, ROLL_SLICE[k]};
              shown[d] = acc;
            end
            steps[d] = s;
          end
        end
        default: ;
      endcase

      // brightness pair for this mode
      s = (steps[d] > FULL_LEVEL) ? FULL_LEVEL : steps[d];
      case (mode)
        MODE_CUT, MODE_STROKE, MODE_ROLL: begin
          o.new_lvl = FULL_LEVEL; o.old_lvl = '0;
        end
        MODE_XFADE: begin
          o.new_lvl = level_t'(s); o.old_lvl = level_t'(FULL_LEVEL - s);
        end
        MODE_FADE: begin
          if (ph[d] == PH_FIRST) begin
            o.new_lvl = '0; o.old_lvl = level_t'(FULL_LEVEL - s);
          end else if (ph[d] == PH_SECOND) begin
            o.new_lvl = level_t'(s); o.old_lvl = '0;
          end else begin
            o.new_lvl = FULL_LEVEL; o.old_lvl = '0;
          end
        end
        default: begin
          o.new_lvl = '0; o.old_lvl = '0;
        end
      endcase
      o.shown = shown[d];
      o.prior = prior[d];
      return o;
    endfunction

    function void note_request(tick_t r);
      frames_due.push_back(animate_tick(r));
    endfunction

    function void check_result(frame_t got);
      frame_t want;
      results_seen++;
      if (frames_due.size() == 0) begin
        fault($sformatf("unexpected result: digit %0d shown %h prior %h levels %0d/%0d",
                        got.digit, got.shown, got.prior, got.new_lvl, got.old_lvl));
        return;
      end
      want = frames_due.pop_front();
      if (got.digit !== want.digit || got.shown !== want.shown ||
          got.prior !== want.prior || got.new_lvl !== want.new_lvl ||
          got.old_lvl !== want.old_lvl)
        fault($sformatf({"mismatch: expected digit %0d shown %h prior %h levels %0d/%0d,",
                         " got digit %0d shown %h prior %h levels %0d/%0d"},
                        want.digit, want.shown, want.prior, want.new_lvl, want.old_lvl,
                        got.digit, got.shown, got.prior, got.new_lvl, got.old_lvl));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, config port and the core itself
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dte_in_if  tick_ch ();
  dte_out_if frame_ch ();

  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  digit_transition_effects_core dut (
    .clk     (clk),
    .rst     (rst),
    .din     (tick_ch),
    .dout    (frame_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  transition_scoreboard sb;
  int   quiet_cycles = 0;
  bit   hold_done = 1'b0;
  int   calm = 0;                 // ticks left in a gap-free stretch
  seg_t wanted [16];              // per-digit target the stimulus is holding

  // --------------------------------------------------------------------------
  // Monitor and watchdog: sample both handshakes on the rising edge. Values
  // read here are the pre-edge ones, so ordering against the drivers is moot.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready)
        sb.note_request('{tick_ch.digit_index, tick_ch.target_segs, tick_ch.digit_value});
      if (frame_ch.valid && frame_ch.ready)
        sb.check_result('{frame_ch.out_digit, frame_ch.shown_segs, frame_ch.prior_segs,
                          frame_ch.new_bright, frame_ch.old_bright});
    end
    if ((tick_ch.valid && tick_ch.ready) || (frame_ch.valid && frame_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready in runs with random gaps, plus one long hold-off once
  // enough results have gone through, so the core fills and stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    frame_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      frame_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12))
        @(posedge clk);
      gap = pick_gap();
      if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
        frame_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (gap > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // offer one tick and hold it until taken; valid stays up for back-to-back
  task automatic offer(input logic [3:0] d, input seg_t t, input logic [3:0] v);
    int gap;
    tick_ch.valid       <= 1'b1;
    tick_ch.digit_index <= d;
    tick_ch.target_segs <= t;
    tick_ch.digit_value <= v;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // program effect_mode once the core has drained, then read it back;
  // the settle wait comes first so the last accepted tick is already noted
  task automatic set_mode(input mode_t m);
    tick_ch.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_EFFECT_MODE;
    pwdata  <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.mode = m;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[2:0] !== m)
      sb.fault($sformatf("mismatch: effect_mode read back expected %0d got %0d", m, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // a fresh target word, biased towards zero, numeral-only and special-only
  function automatic seg_t fresh_target();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 3) return seg_t'($urandom_range(1, 127));
    if (r == 3) return seg_t'($urandom) & ~NUMERAL_MASK;
    if (r == 4) return 16'hFFFF;
    return seg_t'($urandom);
  endfunction

  // one random tick: mostly to the two focus digits so animations run through
  task automatic random_tick(input int focus_a, input int focus_b);
    int r, d;
    logic [3:0] v;
    r = $urandom_range(0, 99);
    if (r < 65)      d = $urandom_range(0, 1) ? focus_a : focus_b;
    else if (r < 95) d = $urandom_range(0, DIGITS - 1);
    else             d = $urandom_range(DIGITS, 15);
    if ($urandom_range(0, 13) == 0) wanted[d] = fresh_target();
    v = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    offer(4'(d), wanted[d], v);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    frame_t lost;
    sb = new();
    rst                 <= 1'b1;
    tick_ch.valid       <= 1'b0;
    tick_ch.digit_index <= '0;
    tick_ch.target_segs <= '0;
    tick_ch.digit_value <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_EFFECT_MODE;
    pwdata  <= '0;
    for (int d = 0; d < 16; d++) wanted[d] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: out-of-range digits and field extremes under the reset mode
    offer(4'd15, 16'hFFFF, 4'd15);
    offer(4'(DIGITS), 16'h1234, 4'd3);
    offer(4'd0, 16'hFFFF, 4'd8);
    offer(4'(DIGITS - 1), 16'h007F, 4'd0);
    offer(4'd0, 16'hFFFF, 4'd8);
    offer(4'd0, 16'hFFFF, 4'd8);

    // stroke: numeral beyond nine, a blank target, then a word with no numeral segments
    set_mode(MODE_STROKE);
    offer(4'd1, 16'h00FF, 4'd12);
    offer(4'd1, 16'h00FF, 4'd12);
    offer(4'd1, 16'h0000, 4'd8);
    offer(4'd1, 16'h0000, 4'd8);
    offer(4'd2, 16'hFF80, 4'd8);
    offer(4'd2, 16'hFF80, 4'd8);

    // undefined code: target is latched but nothing moves
    set_mode(MODE_SPARE_HI);
    offer(4'd3, 16'hABCD, 4'd5);
    offer(4'd3, 16'hABCD, 4'd5);

    // the rest once each; digit 0 is mid-roll when fade takes over
    set_mode(MODE_CUT);
    offer(4'd4, 16'h5555, 4'd9);
    set_mode(MODE_XFADE);
    offer(4'd5, 16'hAAAA, 4'd7);
    offer(4'd5, 16'hAAAA, 4'd7);
    set_mode(MODE_FADE);
    offer(4'd6, 16'h0F0F, 4'd6);
    offer(4'd6, 16'h0F0F, 4'd6);
    offer(4'd0, 16'hFFFF, 4'd8);

    // random part, one focus pair per mode setting
    foreach (RUN_MODES[i]) begin
      int fa, fb;
      set_mode(RUN_MODES[i]);
      fa = $urandom_range(0, DIGITS - 1);
      fb = $urandom_range(0, DIGITS - 1);
      repeat (PHASE_TICKS) random_tick(fa, fb);
    end

    // let the last tick be noted, then drain; a stuck result trips the watchdog
    tick_ch.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    while (sb.pending() != 0) begin
      lost = sb.frames_due.pop_front();
      sb.fault($sformatf("missing result for digit %0d", lost.digit));
    end
    if (sb.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

FILE: digit_transition_effects_core.f
rtl/dte_pkg.sv
rtl/dte_in_if.sv
rtl/dte_out_if.sv
rtl/digit_transition_effects_core.sv
test/tb_digit_transition_effects_core.sv
